// ----- hdl/kfe_pkg.sv -----
// kfe_pkg: shared widths, register indexes, reset values and the
// configuration view handed from the setup sequencer to the pipeline
// no dependencies
package kfe_pkg;

	localparam int QUERY_W    = 16;
	localparam int SPEED_W    = 17;
	localparam int RATE_W     = 14;
	localparam int POS_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// clamped times: one past the largest query time is enough to decide t < limit
	localparam int                 TCL_W     = QUERY_W + 1;
	localparam logic [TCL_W-1:0]   TIME_SPAN = TCL_W'(1) << QUERY_W;

	// wide position sums, covers every frac_bits setting from 4 up
	localparam int ACC_W = 42;
	typedef logic signed [ACC_W-1:0] acc_t;

	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_SPEED    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_CAP      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DECEL_RATE     = 3'd4;

	// register reset values
	localparam logic signed [POS_W-1:0] RST_START_POSITION = '0;
	localparam logic [SPEED_W-1:0]      RST_START_SPEED    = 17'd0;
	localparam logic [SPEED_W-1:0]      RST_SPEED_CAP      = 17'd30720;
	localparam logic [RATE_W-1:0]       RST_ACCEL_RATE     = 14'd4096;
	localparam logic [RATE_W-1:0]       RST_DECEL_RATE     = 14'd6144;

	typedef struct packed {
		logic                       ready;     // derived values are current
		logic signed [POS_W-1:0]    position;
		logic [SPEED_W-1:0]         speed;
		logic [SPEED_W-1:0]         cap;
		logic [RATE_W-1:0]          accel;     // zero already mapped to one
		logic [RATE_W-1:0]          decel;     // zero already mapped to one
		logic                       below_cap; // start speed under the limit
		logic [TCL_W-1:0]           tz;        // stop time, clamped
		logic [TCL_W-1:0]           tl;        // time to reach the limit, clamped
		acc_t                       sl;        // position where the limit is reached
		acc_t                       sz;        // stop position
	} env_ctx_t;

endpackage

// ----- hdl/kfe_query_if.sv -----
// kfe_query_if: query channel, valid/ready with the query time
// depends on kfe_pkg
interface kfe_query_if;
	import kfe_pkg::*;

	logic               valid;
	logic               ready;
	logic [QUERY_W-1:0] query_time;

	modport source(output valid, output query_time, input ready);
	modport sink(input valid, input query_time, output ready);
endinterface

// ----- hdl/kfe_result_if.sv -----
// kfe_result_if: result channel, valid/ready with position and speed bounds
// depends on kfe_pkg
interface kfe_result_if;
	import kfe_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_upper;
	logic signed [POS_W-1:0] pos_lower;
	logic [SPEED_W-1:0]      speed_upper;
	logic [SPEED_W-1:0]      speed_lower;

	modport source(output valid, output pos_upper, output pos_lower,
		output speed_upper, output speed_lower, input ready);
	modport sink(input valid, input pos_upper, input pos_lower,
		input speed_upper, input speed_lower, output ready);
endinterface

// ----- hdl/kfe_cfg_if.sv -----
// kfe_cfg_if: register write channel, valid/ready with index and data
// depends on kfe_pkg
interface kfe_cfg_if;
	import kfe_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ----- hdl/kfe_div.sv -----
// kfe_div: unsigned restoring divider, one quotient bit per cycle
// no package dependencies
module kfe_div #(
	parameter int NUM_W = 34,
	parameter int DEN_W = 15
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= num_q << 1;
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ----- hdl/kfe_setup.sv -----
// kfe_setup: configuration registers and the sequencer that derives stop
// time, stop position, limit time and limit position; uses kfe_div
// depends on kfe_pkg, kfe_cfg_if, kfe_div
module kfe_setup #(
	parameter int FRAC_BITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	kfe_cfg_if.sink           cfg,
	output kfe_pkg::env_ctx_t ctx
);
	import kfe_pkg::*;

	localparam int F         = FRAC_BITS;
	localparam int DIV_NUM_W = (SPEED_W + F > 2 * SPEED_W) ? SPEED_W + F : 2 * SPEED_W;
	localparam int DEN_W     = RATE_W + 1;
	localparam int PA_W      = SPEED_W + TCL_W;
	localparam int PB_W      = RATE_W + TCL_W;
	localparam int PC_W      = PB_W - F + TCL_W;

	typedef enum logic [3:0] {
		ST_LAUNCH_TZ,
		ST_WAIT_TZ,
		ST_LAUNCH_TL,
		ST_WAIT_TL,
		ST_LAUNCH_SZ,
		ST_WAIT_SZ,
		ST_MUL_A,
		ST_MUL_B,
		ST_SUM,
		ST_READY
	} state_t;

	state_t                  state_q;
	logic signed [POS_W-1:0] pos_q;
	logic [SPEED_W-1:0]      speed_q;
	logic [SPEED_W-1:0]      cap_q;
	logic [RATE_W-1:0]       accel_q;
	logic [RATE_W-1:0]       decel_q;
	logic [TCL_W-1:0]        tz_q;
	logic [TCL_W-1:0]        tl_q;
	acc_t                    sz_q;
	acc_t                    sl_q;
	logic [PA_W-1:0]         pa_q;
	logic [PB_W-1:0]         pb_q;
	logic [PC_W-1:0]         pc_q;

	logic [RATE_W-1:0]    acc_nz;
	logic [RATE_W-1:0]    dec_nz;
	logic [2*SPEED_W-1:0] sq;
	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DEN_W-1:0]     div_den;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quo;
	logic [TCL_W-1:0]     quo_clamp;

	always_comb begin
		acc_nz    = (accel_q == '0) ? RATE_W'(1) : accel_q;
		dec_nz    = (decel_q == '0) ? RATE_W'(1) : decel_q;
		sq        = speed_q * speed_q;
		quo_clamp = (div_quo > DIV_NUM_W'(TIME_SPAN)) ? TIME_SPAN : div_quo[TCL_W-1:0];
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			ST_LAUNCH_TZ: begin
				div_start = 1'b1;
				div_num   = DIV_NUM_W'(speed_q) << F;
				div_den   = DEN_W'(dec_nz);
			end
			ST_LAUNCH_TL: begin
				div_start = 1'b1;
				div_num   = DIV_NUM_W'(cap_q - speed_q) << F;
				div_den   = DEN_W'(acc_nz);
			end
			ST_LAUNCH_SZ: begin
				div_start = 1'b1;
				div_num   = DIV_NUM_W'(sq);
				div_den   = {dec_nz, 1'b0};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	kfe_div #(
		.NUM_W(DIV_NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LAUNCH_TZ;
			pos_q   <= RST_START_POSITION;
			speed_q <= RST_START_SPEED;
			cap_q   <= RST_SPEED_CAP;
			accel_q <= RST_ACCEL_RATE;
			decel_q <= RST_DECEL_RATE;
			tz_q    <= '0;
			tl_q    <= '0;
			sz_q    <= '0;
			sl_q    <= '0;
			pa_q    <= '0;
			pb_q    <= '0;
			pc_q    <= '0;
		end else if (cfg.valid) begin
			// any write restarts the derivation
			state_q <= ST_LAUNCH_TZ;
			unique case (cfg.index)
				REG_START_POSITION: pos_q   <= cfg.data[POS_W-1:0];
				REG_START_SPEED:    speed_q <= cfg.data[SPEED_W-1:0];
				REG_SPEED_CAP:      cap_q   <= cfg.data[SPEED_W-1:0];
				REG_ACCEL_RATE:     accel_q <= cfg.data[RATE_W-1:0];
				REG_DECEL_RATE:     decel_q <= cfg.data[RATE_W-1:0];
				default:            ;
			endcase
		end else begin
			unique case (state_q)
				ST_LAUNCH_TZ: state_q <= ST_WAIT_TZ;
				ST_WAIT_TZ: begin
					if (div_done) begin
						tz_q    <= quo_clamp;
						state_q <= ST_LAUNCH_TL;
					end
				end
				ST_LAUNCH_TL: state_q <= ST_WAIT_TL;
				ST_WAIT_TL: begin
					if (div_done) begin
						tl_q    <= quo_clamp;
						state_q <= ST_LAUNCH_SZ;
					end
				end
				ST_LAUNCH_SZ: state_q <= ST_WAIT_SZ;
				ST_WAIT_SZ: begin
					if (div_done) begin
						sz_q    <= acc_t'(pos_q) + acc_t'(div_quo);
						state_q <= ST_MUL_A;
					end
				end
				ST_MUL_A: begin
					pa_q    <= speed_q * tl_q;
					pb_q    <= acc_nz * tl_q;
					state_q <= ST_MUL_B;
				end
				ST_MUL_B: begin
					pc_q    <= pb_q[PB_W-1:F] * tl_q;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					// position at the limit, same terms as the accelerating branch
					sl_q    <= acc_t'(pos_q) + acc_t'(pa_q[PA_W-1:F])
						+ acc_t'(pc_q[PC_W-1:F+1]);
					state_q <= ST_READY;
				end
				ST_READY: state_q <= ST_READY;
				default:  state_q <= ST_LAUNCH_TZ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	always_comb begin
		ctx.ready     = state_q == ST_READY;
		ctx.position  = pos_q;
		ctx.speed     = speed_q;
		ctx.cap       = cap_q;
		ctx.accel     = acc_nz;
		ctx.decel     = dec_nz;
		ctx.below_cap = speed_q < cap_q;
		ctx.tz        = tz_q;
		ctx.tl        = tl_q;
		ctx.sl        = sl_q;
		ctx.sz        = sz_q;
	end
endmodule

// ----- hdl/kfe_datapath.sv -----
// kfe_datapath: four-stage envelope pipeline with per-stage valid bits
// and bubble-collapsing stall control
// depends on kfe_pkg, kfe_query_if, kfe_result_if
module kfe_datapath #(
	parameter int FRAC_BITS = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  kfe_pkg::env_ctx_t ctx,
	kfe_query_if.sink        query,
	kfe_result_if.source     result
);
	import kfe_pkg::*;

	localparam int F      = FRAC_BITS;
	localparam int VT_W   = SPEED_W + QUERY_W;
	localparam int VTS_W  = VT_W - F;
	localparam int AT_W   = RATE_W + QUERY_W;
	localparam int ATS_W  = AT_W - F;
	localparam int H_W    = ATS_W + QUERY_W;
	localparam int CR_W   = SPEED_W + QUERY_W;
	localparam int G_W    = ((ATS_W > SPEED_W) ? ATS_W : SPEED_W) + 1;

	typedef enum logic [1:0] {
		UP_ACCEL,
		UP_LIMITED,
		UP_HOLD
	} up_mode_t;

	function automatic logic signed [POS_W-1:0] sat_pos(input acc_t x);
		logic signed [POS_W-1:0] r;
		begin
			if (x > acc_t'(POS_MAX)) begin
				r = POS_MAX;
			end else if (x < acc_t'(POS_MIN)) begin
				r = POS_MIN;
			end else begin
				r = x[POS_W-1:0];
			end
			return r;
		end
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	logic accept;

	// stage 1
	logic [QUERY_W-1:0] t_s1;
	logic [VT_W-1:0]    vt_s1;
	logic [AT_W-1:0]    at_s1;
	logic [AT_W-1:0]    dt_s1;
	logic [QUERY_W-1:0] rem_s1;
	up_mode_t           mode_s1;
	logic               below_tz_s1;
	up_mode_t           mode_d;
	logic [TCL_W-1:0]   t_ext;

	// stage 2
	logic [H_W-1:0]     ha_s2;
	logic [H_W-1:0]     hd_s2;
	logic [CR_W-1:0]    cr_s2;
	logic [VTS_W-1:0]   vt_s2;
	up_mode_t           mode_s2;
	logic               below_tz_s2;
	logic [SPEED_W-1:0] vu_s2;
	logic [SPEED_W-1:0] vl_s2;
	logic [ATS_W-1:0]   ats;
	logic [ATS_W-1:0]   dts;
	logic [G_W-1:0]     gain;
	logic [SPEED_W-1:0] capped;
	logic [SPEED_W-1:0] vu_d;
	logic [SPEED_W-1:0] vl_d;

	// stage 3
	acc_t               pu_s3;
	acc_t               pl_s3;
	logic [SPEED_W-1:0] vu_s3;
	logic [SPEED_W-1:0] vl_s3;
	acc_t               lin;
	acc_t               pu_d;
	acc_t               pl_d;

	// stage 4, the output register
	logic signed [POS_W-1:0] pu_s4;
	logic signed [POS_W-1:0] pl_s4;
	logic [SPEED_W-1:0]      vu_s4;
	logic [SPEED_W-1:0]      vl_s4;

	always_comb begin
		en4    = !v_s4 || result.ready;
		en3    = !v_s3 || en4;
		en2    = !v_s2 || en3;
		en1    = !v_s1 || en2;
		accept = query.valid && en1 && ctx.ready;
	end

	assign query.ready = en1 && ctx.ready;

	always_comb begin
		t_ext = TCL_W'(query.query_time);
		priority if (!ctx.below_cap) begin
			mode_d = UP_HOLD;
		end else if (t_ext < ctx.tl) begin
			mode_d = UP_ACCEL;
		end else begin
			mode_d = UP_LIMITED;
		end
	end

	always_comb begin
		ats    = at_s1[AT_W-1:F];
		dts    = dt_s1[AT_W-1:F];
		gain   = G_W'(ctx.speed) + G_W'(ats);
		capped = (gain < G_W'(ctx.cap)) ? SPEED_W'(gain) : ctx.cap;
		vu_d   = (capped < ctx.speed) ? ctx.speed : capped;
		vl_d   = below_tz_s1 ? ctx.speed - SPEED_W'(dts) : '0;
	end

	always_comb begin
		lin = acc_t'(ctx.position) + acc_t'(vt_s2);
		unique case (mode_s2)
			UP_ACCEL:   pu_d = lin + acc_t'(ha_s2[H_W-1:F+1]);
			UP_LIMITED: pu_d = ctx.sl + acc_t'(cr_s2[CR_W-1:F]);
			UP_HOLD:    pu_d = lin;
			default:    pu_d = lin;
		endcase
		pl_d = below_tz_s2 ? lin - acc_t'(hd_s2[H_W-1:F+1]) : ctx.sz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= accept;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			t_s1        <= query.query_time;
			vt_s1       <= ctx.speed * query.query_time;
			at_s1       <= ctx.accel * query.query_time;
			dt_s1       <= ctx.decel * query.query_time;
			rem_s1      <= query.query_time - ctx.tl[QUERY_W-1:0];
			mode_s1     <= mode_d;
			below_tz_s1 <= t_ext < ctx.tz;
		end
		if (en2) begin
			ha_s2       <= ats * t_s1;
			hd_s2       <= dts * t_s1;
			cr_s2       <= ctx.cap * rem_s1;
			vt_s2       <= vt_s1[VT_W-1:F];
			mode_s2     <= mode_s1;
			below_tz_s2 <= below_tz_s1;
			vu_s2       <= vu_d;
			vl_s2       <= vl_d;
		end
		if (en3) begin
			pu_s3 <= pu_d;
			pl_s3 <= pl_d;
			vu_s3 <= vu_s2;
			vl_s3 <= vl_s2;
		end
		if (en4) begin
			pu_s4 <= sat_pos(pu_s3);
			pl_s4 <= sat_pos(pl_s3);
			vu_s4 <= vu_s3;
			vl_s4 <= vl_s3;
		end
	end

	assign result.valid       = v_s4;
	assign result.pos_upper   = pu_s4;
	assign result.pos_lower   = pl_s4;
	assign result.speed_upper = vu_s4;
	assign result.speed_lower = vl_s4;
endmodule

// ----- hdl/kinematic_feasible_envelope.sv -----
// kinematic_feasible_envelope: reachable position and speed bounds per query time
// pipeline: four register stages, s1 through s4, the last being the output register
// throughput: one query per cycle when not stalled and setup is ready, set by kfe_datapath
// stalls hold every stage; empty stages fill, so input blocks only once all four are full
// after reset and after every register write, query.ready stays low while the one-bit-per-cycle
// divider derives stop time, limit time and stop position (three divisions), then limit position
module kinematic_feasible_envelope #(
	parameter int FRAC_BITS = 10
) (
	input  logic         clk,
	input  logic         arst_n,
	kfe_query_if.sink    query,
	kfe_result_if.source result,
	kfe_cfg_if.sink      cfg
);
	import kfe_pkg::*;

	// register view plus derived stop/limit values, steady between writes
	env_ctx_t ctx;

	// registers and the derivation sequencer (shared iterative divider)
	kfe_setup #(
		.FRAC_BITS(FRAC_BITS)
	) u_setup (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.ctx   (ctx)
	);

	// per-item pipeline: products, half terms and speeds, sums, saturation
	kfe_datapath #(
		.FRAC_BITS(FRAC_BITS)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.ctx   (ctx),
		.query (query),
		.result(result)
	);
endmodule
